// ===== hw/rtl/bprle_pkg.sv =====
// shared types and constants of the bit-packed run-length pixel decoder
// no dependencies; imported by every module of the block

package bprle_pkg;

  // stream limits
  localparam int unsigned MAX_LENGTH_BITS = 16;
  localparam int unsigned MAX_VALUE_BITS  = 8;

  // configuration register indexes
  localparam logic [1:0] CFG_VALUE_BITS  = 2'd0;
  localparam logic [1:0] CFG_LENGTH_BITS = 2'd1;
  localparam logic [1:0] CFG_PIXEL_COUNT = 2'd2;

  // configuration reset values
  localparam logic [3:0]  VALUE_BITS_RST  = 4'd8;
  localparam logic [4:0]  LENGTH_BITS_RST = 5'd8;
  localparam logic [31:0] PIXEL_COUNT_RST = 32'd1;

  // field parser phase
  typedef enum logic [1:0] {
    PH_KIND = 2'd0,
    PH_LEN  = 2'd1,
    PH_VAL  = 2'd2
  } phase_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_BIT  = 2'd1,
    ST_CALC = 2'd2,
    ST_EMIT = 2'd3
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load_byte;
    logic step_bit;
    logic load_rem;
    logic emit_tok;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic val_done;
    logic last_bit;
    logic byte_end;
    logic out_full;
  } sts_t;

endpackage

// ===== hw/rtl/bprle_ctrl.sv =====
// controller state machine of the run-length pixel decoder
// depends on bprle_pkg; drives the datapath through cmd_t, watches sts_t

module bprle_ctrl import bprle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_BIT;
      end
      ST_BIT: begin
        if (sts_i.val_done) begin
          state_d = ST_CALC;
        end else if (sts_i.last_bit) begin
          state_d = ST_IDLE;
        end
      end
      ST_CALC: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts_i.out_full) begin
          state_d = sts_i.byte_end ? ST_IDLE : ST_BIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_byte = in_valid_i;
      end
      ST_BIT: begin
        cmd_o.step_bit = 1'b1;
      end
      ST_CALC: begin
        cmd_o.load_rem = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit_tok = !sts_i.out_full;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bprle_datapath.sv =====
// datapath of the run-length pixel decoder: config registers, bit shifter,
// field parser, pixel counting and the output token register
// depends on bprle_pkg; commanded by bprle_ctrl

module bprle_datapath import bprle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        start_image_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [7:0]  pixel_value_o,
  output logic [16:0] repeat_count_o,
  output logic        image_done_o,
  output logic        overrun_o
);

  // configuration
  logic [3:0]  value_bits_q;
  logic [4:0]  length_bits_q;
  logic [31:0] pixel_count_q;

  // decode state
  phase_e      ph_q;
  logic [15:0] acc_q;
  logic [4:0]  taken_q;
  logic        kind_q;
  logic [16:0] ll_q;
  logic [31:0] pd_q;
  logic        fin_q;

  // byte shifter and per-token scratch
  logic [7:0]  sh_q;
  logic [3:0]  left_q;
  logic [7:0]  val_q;
  logic [31:0] rem_q;

  // output token register
  logic        out_valid_q;
  logic [7:0]  out_val_q;
  logic [16:0] out_cnt_q;
  logic        out_done_q;
  logic        out_ov_q;

  // clamped widths
  logic [3:0] evb;
  logic [4:0] elen;
  always_comb begin
    evb = value_bits_q;
    if (value_bits_q == 4'd0) evb = 4'd1;
    if (value_bits_q > 4'(MAX_VALUE_BITS)) evb = 4'(MAX_VALUE_BITS);
    elen = length_bits_q;
    if (length_bits_q > 5'(MAX_LENGTH_BITS)) elen = 5'(MAX_LENGTH_BITS);
  end

  logic bit_in;
  logic active;
  assign bit_in = sh_q[7];
  assign active = !fin_q && (pd_q < pixel_count_q);

  // one stream bit through the field parser
  phase_e      cur_ph, ph_step;
  logic [15:0] cur_acc, acc_shift, acc_step;
  logic [4:0]  cur_taken, taken_inc, taken_step;
  logic [16:0] ll_step;
  logic        kind_step;
  logic        val_hit;
  logic [7:0]  val_step;
  always_comb begin
    cur_ph     = ph_q;
    cur_acc    = acc_q;
    cur_taken  = taken_q;
    ll_step    = ll_q;
    kind_step  = kind_q;
    val_hit    = 1'b0;
    val_step   = val_q;
    // empty or already full length field completes first
    if (ph_q == PH_LEN && taken_q >= elen) begin
      cur_ph    = PH_VAL;
      ll_step   = {1'b0, acc_q} + 17'd1;
      cur_acc   = '0;
      cur_taken = '0;
    end
    taken_inc  = cur_taken + 5'd1;
    acc_shift  = {cur_acc[14:0], bit_in};
    ph_step    = cur_ph;
    acc_step   = acc_shift;
    taken_step = taken_inc;
    case (cur_ph)
      PH_LEN: begin
        if (taken_inc >= elen) begin
          ll_step    = {1'b0, acc_shift} + 17'd1;
          ph_step    = PH_VAL;
          acc_step   = '0;
          taken_step = '0;
        end
      end
      PH_VAL: begin
        acc_step = {8'd0, acc_shift[7:0]};
        if (taken_inc >= {1'b0, evb}) begin
          val_hit    = 1'b1;
          val_step   = acc_shift[7:0];
          acc_step   = '0;
          taken_step = '0;
        end
      end
      default: begin
        kind_step  = bit_in;
        ph_step    = PH_LEN;
        acc_step   = '0;
        taken_step = '0;
      end
    endcase
  end

  // token counting and clipping
  logic [16:0] ll_dec, ll_emit, tok_cnt;
  logic        rep_over, rep_reach, tok_done, tok_ov;
  phase_e      ph_emit;
  always_comb begin
    ll_dec    = (ll_q != 17'd0) ? ll_q - 17'd1 : 17'd0;
    rep_over  = {15'd0, ll_q} > rem_q;
    rep_reach = {15'd0, ll_q} >= rem_q;
    if (kind_q) begin
      tok_cnt  = 17'd1;
      tok_done = (rem_q == 32'd1);
      tok_ov   = tok_done && (ll_dec != 17'd0);
      ll_emit  = ll_dec;
      ph_emit  = (ll_dec == 17'd0) ? PH_KIND : PH_VAL;
    end else begin
      tok_cnt  = rep_over ? rem_q[16:0] : ll_q;
      tok_done = rep_reach;
      tok_ov   = rep_over;
      ll_emit  = '0;
      ph_emit  = PH_KIND;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_bits_q  <= VALUE_BITS_RST;
      length_bits_q <= LENGTH_BITS_RST;
      pixel_count_q <= PIXEL_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_VALUE_BITS:  value_bits_q  <= cfg_data_i[3:0];
        CFG_LENGTH_BITS: length_bits_q <= cfg_data_i[4:0];
        CFG_PIXEL_COUNT: pixel_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_KIND;
      acc_q   <= '0;
      taken_q <= '0;
      kind_q  <= 1'b0;
      ll_q    <= '0;
      pd_q    <= '0;
      fin_q   <= 1'b0;
    end else if (cmd_i.load_byte) begin
      if (start_image_i) begin
        ph_q    <= PH_KIND;
        acc_q   <= '0;
        taken_q <= '0;
        kind_q  <= 1'b0;
        ll_q    <= '0;
        pd_q    <= '0;
        fin_q   <= 1'b0;
      end
    end else if (cmd_i.step_bit && active) begin
      ph_q    <= ph_step;
      acc_q   <= acc_step;
      taken_q <= taken_step;
      kind_q  <= kind_step;
      ll_q    <= ll_step;
    end else if (cmd_i.emit_tok) begin
      ph_q <= ph_emit;
      ll_q <= ll_emit;
      pd_q <= pd_q + {15'd0, tok_cnt};
      if (tok_done) fin_q <= 1'b1;
    end
  end

  // bit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (cmd_i.load_byte) begin
      left_q <= 4'd8;
    end else if (cmd_i.step_bit) begin
      left_q <= left_q - 4'd1;
    end
  end

  // byte shifter, finished value and pixels remaining
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      sh_q <= stream_byte_i;
    end else if (cmd_i.step_bit) begin
      sh_q <= {sh_q[6:0], 1'b0};
    end
    if (cmd_i.step_bit && active && val_hit) val_q <= val_step;
    if (cmd_i.load_rem) rem_q <= pixel_count_q - pd_q;
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_tok) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_tok) begin
      out_val_q  <= val_q;
      out_cnt_q  <= tok_cnt;
      out_done_q <= tok_done;
      out_ov_q   <= tok_ov;
    end
  end

  // status
  assign sts_o.val_done = active && val_hit;
  assign sts_o.last_bit = (left_q == 4'd1);
  assign sts_o.byte_end = (left_q == 4'd0);
  assign sts_o.out_full = out_valid_q && out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = out_val_q;
  assign repeat_count_o = out_cnt_q;
  assign image_done_o   = out_done_q;
  assign overrun_o      = out_ov_q;

endmodule

// ===== hw/rtl/bit_packed_rle_pixel_decoder.sv =====
// Bit-packed run-length pixel decoder. A stream byte is taken in the idle
// state and its bits are then parsed one per cycle, most significant first,
// except that the parse pauses for each run token a bit completes
// (remaining-pixel subtract, then clip and count update) and while a token
// waits for a stalled output register; the input is stalled meanwhile.
// A new byte can be taken while an emitted token still waits in the output
// register. Depends on bprle_pkg, bprle_ctrl and bprle_datapath.

module bit_packed_rle_pixel_decoder import bprle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        start_image_i,
  // run token output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  pixel_value_o,
  output logic [16:0] repeat_count_o,
  output logic        image_done_o,
  output logic        overrun_o,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  bprle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // parsing, counting and output register
  bprle_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .stream_byte_i  (stream_byte_i),
    .start_image_i  (start_image_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .pixel_value_o  (pixel_value_o),
    .repeat_count_o (repeat_count_o),
    .image_done_o   (image_done_o),
    .overrun_o      (overrun_o)
  );

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the bit-packed run-length pixel decoder
// holds its own decoder model in a scoreboard class; depends on bprle_pkg and the rtl top

module tb_top;
  import bprle_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_BYTES    = 34;

  // one decoded run token
  typedef struct packed {
    logic [7:0]  value;
    logic [16:0] count;
    logic        done;
    logic        ovr;
  } token_t;

  // decoder model and queue of tokens still to arrive
  class token_board;
    logic [3:0]  vb_reg;
    logic [4:0]  lb_reg;
    logic [31:0] pc_reg;
    logic [15:0] acc;
    logic [4:0]  taken;
    phase_e      phase;
    logic        is_lit;
    logic [16:0] left;
    logic [31:0] px_done;
    logic        finished;
    token_t      want_q[$];
    int unsigned errors;
    int unsigned tokens_seen;

    function new();
      vb_reg = VALUE_BITS_RST;
      lb_reg = LENGTH_BITS_RST;
      pc_reg = PIXEL_COUNT_RST;
      errors = 0;
      tokens_seen = 0;
      clear_image();
    endfunction

    function void clear_image();
      acc      = '0;
      taken    = '0;
      phase    = PH_KIND;
      is_lit   = 1'b0;
      left     = '0;
      px_done  = '0;
      finished = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_VALUE_BITS:  vb_reg = data[3:0];
        CFG_LENGTH_BITS: lb_reg = data[4:0];
        CFG_PIXEL_COUNT: pc_reg = data;
        default: ;
      endcase
    endfunction

    // value width as the decoder clamps it
    function int unsigned value_width();
      if (vb_reg == 0) return 1;
      if (vb_reg > MAX_VALUE_BITS) return MAX_VALUE_BITS;
      return 32'(vb_reg);
    endfunction

    function int unsigned length_width();
      if (lb_reg > MAX_LENGTH_BITS) return MAX_LENGTH_BITS;
      return 32'(lb_reg);
    endfunction

    // size field complete: move on to the value fields
    function void length_complete();
      left  = {1'b0, acc} + 17'd1;
      phase = PH_VAL;
      acc   = '0;
      taken = '0;
    endfunction

    // one accepted stream byte, msb first
    function void note_byte(logic [7:0] b, logic s);
      token_t      t;
      logic [31:0] remaining;
      logic [31:0] cnt;
      logic        bitv;
      if (s) clear_image();
      for (int i = 7; i >= 0; i--) begin
        bitv = b[i];
        if (finished || px_done >= pc_reg) continue;
        // an empty or already full size field closes before the next bit
        if (phase == PH_LEN && taken >= length_width()) length_complete();
        case (phase)
          PH_LEN: begin
            acc   = {acc[14:0], bitv};
            taken = taken + 5'd1;
            if (taken >= length_width()) length_complete();
          end
          PH_VAL: begin
            acc   = {8'd0, acc[6:0], bitv};
            taken = taken + 5'd1;
            if (taken >= value_width()) begin
              t.value   = acc[7:0];
              remaining = pc_reg - px_done;
              acc       = '0;
              taken     = '0;
              if (is_lit) begin
                px_done = px_done + 32'd1;
                if (left > 0) left = left - 17'd1;
                t.count = 17'd1;
                t.done  = (px_done >= pc_reg);
                t.ovr   = t.done && (left > 0);
                if (left == 0) phase = PH_KIND;
              end else begin
                // repeat run clipped at the image end
                cnt   = {15'd0, left};
                t.ovr = 1'b0;
                if (cnt > remaining) begin
                  cnt   = remaining;
                  t.ovr = 1'b1;
                end
                px_done = px_done + cnt;
                t.done  = (px_done >= pc_reg);
                t.count = cnt[16:0];
                left    = '0;
                phase   = PH_KIND;
              end
              want_q.push_back(t);
              if (t.done) finished = 1'b1;
            end
          end
          default: begin
            is_lit = bitv;
            phase  = PH_LEN;
            acc    = '0;
            taken  = '0;
          end
        endcase
      end
    endfunction

    // compare one output transfer with the oldest expected token
    function void check_token(token_t got);
      token_t want;
      tokens_seen++;
      if (want_q.size() == 0) begin
        $error("unexpected run token: pixel_value %0d repeat_count %0d", got.value, got.count);
        errors++;
        return;
      end
      want = want_q.pop_front();
      if (got.value !== want.value) begin
        $error("pixel_value expected %0d actual %0d", want.value, got.value);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("repeat_count expected %0d actual %0d", want.count, got.count);
        errors++;
      end
      if (got.done !== want.done) begin
        $error("image_done expected %0d actual %0d", want.done, got.done);
        errors++;
      end
      if (got.ovr !== want.ovr) begin
        $error("overrun expected %0d actual %0d", want.ovr, got.ovr);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [7:0]  stream_byte_i = 8'd0;
  logic        start_image_i = 1'b0;
  logic        out_stall_i   = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = CFG_VALUE_BITS;
  logic [31:0] cfg_data_i    = 32'd0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  pixel_value_o;
  logic [16:0] repeat_count_o;
  logic        image_done_o;
  logic        overrun_o;

  token_board  board = new();
  logic        bitq[$];
  int unsigned bytes_sent    = 0;
  int unsigned settings_used = 0;
  int unsigned hold_asked    = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet         = 0;

  bit_packed_rle_pixel_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .stream_byte_i  (stream_byte_i),
    .start_image_i  (start_image_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_value_o  (pixel_value_o),
    .repeat_count_o (repeat_count_o),
    .image_done_o   (image_done_o),
    .overrun_o      (overrun_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // idle rates: sender light then heavy, then none at all
  function automatic int unsigned send_idle_pct();
    if (bytes_sent < 145) return 13;
    if (bytes_sent < 290) return 59;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (bytes_sent < 145) return 59;
    if (bytes_sent < 290) return 13;
    return 0;
  endfunction

  // receiver stall, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct());
    end
  end

  // output transfer check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_token({pixel_value_o, repeat_count_o, image_done_o, overrun_o});
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // offer one stream byte and wait for its transfer
  task automatic send_byte(input logic [7:0] b, input logic s);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < send_idle_pct()) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    start_image_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_byte(b, s);
    bytes_sent++;
  endtask

  // wait until every expected token is out and the block has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.want_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [3:0] vb, input logic [4:0] lb, input logic [31:0] pc);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_VALUE_BITS;
    cfg_data_i  <= {28'd0, vb};
    @(posedge clk_i);
    board.set_reg(CFG_VALUE_BITS, {28'd0, vb});
    cfg_index_i <= CFG_LENGTH_BITS;
    cfg_data_i  <= {27'd0, lb};
    @(posedge clk_i);
    board.set_reg(CFG_LENGTH_BITS, {27'd0, lb});
    cfg_index_i <= CFG_PIXEL_COUNT;
    cfg_data_i  <= pc;
    @(posedge clk_i);
    board.set_reg(CFG_PIXEL_COUNT, pc);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic void put_bits(input logic [31:0] v, input int unsigned n);
    for (int i = int'(n) - 1; i >= 0; i--) bitq.push_back(v[i]);
  endfunction

  // pad the bit queue to whole bytes and send it, new-image flag on the first
  task automatic send_bits(input logic first_start);
    logic [7:0] b;
    logic       s;
    s = first_start;
    if (bitq.size() == 0) put_bits($urandom, 8);
    while (bitq.size() % 8 != 0) bitq.push_back(1'($urandom_range(0, 1)));
    while (bitq.size() != 0) begin
      for (int i = 7; i >= 0; i--) b[i] = bitq.pop_front();
      send_byte(b, s);
      s = 1'b0;
    end
  endtask

  // up to ten well-formed blocks toward the image size, random kinds, sizes and values
  function automatic void build_image();
    int unsigned vw, lw, covered, blocks, maxsz, lim, size;
    logic        kind;
    vw      = board.value_width();
    lw      = board.length_width();
    covered = 0;
    blocks  = 0;
    maxsz   = 1 << lw;
    lim     = (maxsz < 40) ? maxsz : 40;
    while (covered < board.pc_reg && blocks < 10) begin
      kind = 1'($urandom_range(0, 1));
      if (kind) size = $urandom_range(1, (lim < 6) ? lim : 6);
      else if ($urandom_range(0, 9) == 0) size = maxsz;
      else size = $urandom_range(1, lim);
      bitq.push_back(kind);
      put_bits(size - 1, lw);
      repeat (kind ? size : 1) put_bits($urandom, vw);
      covered += size;
      blocks++;
    end
  endfunction

  initial begin
    int unsigned budget, r, cut;
    logic [3:0]  vb;
    logic [4:0]  lb;
    logic [31:0] pc;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: repeat run clipped to the single pixel, then ignored bytes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);

    // widest size field: full 65536 count and a count of one
    write_cfg(4'd8, 5'd16, 32'hFFFE_0001);
    bitq.push_back(1'b0);
    put_bits(32'hFFFF, 16);
    put_bits($urandom, 8);
    bitq.push_back(1'b0);
    put_bits(32'h0000, 16);
    put_bits($urandom, 8);
    send_bits(1'b1);

    // value width above range and an empty size field
    write_cfg(4'd15, 5'd0, 32'd5);
    bitq.push_back(1'b1);
    put_bits($urandom, 8);
    bitq.push_back(1'b0);
    put_bits($urandom, 8);
    bitq.push_back(1'b1);
    put_bits($urandom, 8);
    send_bits(1'b1);

    // zero value width, size width above range, literal run past the image end
    write_cfg(4'd0, 5'd20, 32'd3);
    bitq.push_back(1'b0);
    put_bits(32'd1, 16);
    put_bits($urandom, 1);
    bitq.push_back(1'b1);
    put_bits(32'd3, 16);
    put_bits($urandom, 4);
    send_bits(1'b1);

    // empty image: every bit ignored
    write_cfg(4'd2, 5'd31, 32'd0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);

    // size width shrunk below the bits already taken
    write_cfg(4'd4, 5'd8, 32'd50);
    send_byte(8'h0F, 1'b1);
    write_cfg(4'd4, 5'd3, 32'd50);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h9F, 1'b0);

    // random phases, each under its own register setting
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin vb = 4'd1; lb = 5'd0;  pc = 32'd1;           end
        1: begin vb = 4'd8; lb = 5'd16; pc = 32'hFFFE_0001;   end
        2: begin vb = 4'd4; lb = 5'd3;  pc = 32'd17;          end
        3: begin vb = 4'd8; lb = 5'd16; pc = 32'hFFFF_FFFF;   end
        default: begin
          vb = 4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8));
          lb = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6));
          pc = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 64);
        end
      endcase
      write_cfg(vb, lb, pc);
      // long receiver hold-off so the block backs up into its input
      if (p == 2) hold_asked++;
      budget = bytes_sent + PHASE_BYTES;
      while (bytes_sent < budget) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end else begin
          build_image();
          // truncated image
          if (r == 1) begin
            cut = $urandom_range(0, bitq.size());
            while (bitq.size() > cut) void'(bitq.pop_back());
          end
          // new-image flag set except for a continuation when r is 2
          send_bits(r != 2);
        end
      end
    end

    drain();
    if (board.want_q.size() != 0) board.errors++;
    $display("covered %0d stream bytes and %0d run tokens under %0d register settings",
             bytes_sent, board.tokens_seen, settings_used);
    $display("including a %0d-cycle receiver hold-off and three idle profiles", HOLD_CYCLES);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
